[hdl/bdeq_pkg.sv]
// ---------------------------------------------------------------------------
// Bounded double-ended queue: shared package
// Operation and status codes, controller states and the result word type.
// ---------------------------------------------------------------------------
package bdeq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  // Operation codes carried by an input word.
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // Status codes carried by a result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_e;

  // One result word on its way to the output register.
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] item_value;
    status_e                 status;
    logic                    last;
    logic [OccW-1:0]         occupancy;
  } res_t;

endpackage

[hdl/bounded_double_ended_queue_unit.sv]
// ---------------------------------------------------------------------------
// Bounded double-ended queue unit
// Ring-buffer deque of signed 32-bit words held in a synchronous memory.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | op_i, value_i
//  out     | output    | out_valid_o/ out_stall_i| item_value_o, status_o,
//          |           |                         | last_o, occupancy_o
//
// A push, or any word that meets an empty or full queue, is answered from the idle state.
// A pop reads the store and answers from S_POP, once the registered read data is back.
// A dump reads the store once per entry, pipelined, and flags its last entry on last_o.
// Reset clears the front index and count; the store needs no clearing pass.
// A stalled output holds its word and stops the unit from taking new words.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         op_i,
  input  logic signed [bdeq_pkg::DataW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bdeq_pkg::DataW-1:0]  item_value_o,
  output logic [1:0]                         status_o,
  output logic                               last_o,
  output logic [bdeq_pkg::OccW-1:0]          occupancy_o
);
  import bdeq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t             res;
  logic             res_ready;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [DataW-1:0] rdata;

  logic                    out_valid_q;
  logic signed [DataW-1:0] item_value_q;
  status_e                 status_q;
  logic                    last_q;
  logic [OccW-1:0]         occupancy_q;

  // The output slot can take a word when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  bdeq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  bdeq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload, loaded only when a new word arrives.
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      item_value_q <= res.item_value;
      status_q     <= res.status;
      last_q       <= res.last;
      occupancy_q  <= res.occupancy;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign item_value_o = item_value_q;
  assign status_o     = status_q;
  assign last_o       = last_q;
  assign occupancy_o  = occupancy_q;

endmodule

[hdl/bdeq_ram.sv]
// ---------------------------------------------------------------------------
// Bounded double-ended queue: entry store
// Simple dual-port synchronous memory with one write and one registered read.
// ---------------------------------------------------------------------------
module bdeq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bdeq_ctrl.sv]
// ---------------------------------------------------------------------------
// Bounded double-ended queue: controller
// Keeps the front index and entry count, drives the store and builds results.
// ---------------------------------------------------------------------------
module bdeq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     op_i,
  input  logic signed [bdeq_pkg::DataW-1:0] value_i,
  input  logic                           res_ready_i,
  output bdeq_pkg::res_t                 res_o,
  output logic                           we_o,
  output logic [AW-1:0]                  waddr_o,
  output logic [bdeq_pkg::DataW-1:0]     wdata_o,
  output logic                           re_o,
  output logic [AW-1:0]                  raddr_o,
  input  logic [bdeq_pkg::DataW-1:0]     rdata_i
);
  import bdeq_pkg::*;

  state_e        state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] idx_q, idx_d;

  logic          accept;
  logic          full;
  logic          empty;
  logic          dump_last;
  logic [CW:0]   back_sum;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] ptr_inc;

  // Occupancy is the entry count cut to the width of the result field.
  function automatic logic [OccW-1:0] occ_of(input logic [CW-1:0] cnt);
    logic [CW+OccW-1:0] ext;
    ext = {{OccW{1'b0}}, cnt};
    return ext[OccW-1:0];
  endfunction

  // Step a ring position forward by one.
  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  // Ring positions: one past the back for a back push, the back entry for a back pop.
  assign tail_sum  = (CW+1)'(front_q) + (CW+1)'(count_q);
  assign back_sum  = tail_sum - (CW+1)'(1);
  assign tail_pos  = (tail_sum >= (CW+1)'(DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(DEPTH)) : AW'(tail_sum);
  assign back_pos  = (back_sum >= (CW+1)'(DEPTH)) ?
                     AW'(back_sum - (CW+1)'(DEPTH)) : AW'(back_sum);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = ring_inc(front_q);
  assign ptr_inc   = ring_inc(ptr_q);
  assign dump_last = ((idx_q + CW'(1)) == count_q);

  // A new word is taken only while idle and the output slot can take a result.
  assign in_stall_o = !((state_q == S_IDLE) && res_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((op_i == OP_POP_BACK || op_i == OP_POP_FRONT) && !empty) begin
            state_d = S_POP;
          end else if (op_i == OP_DUMP && !empty) begin
            state_d = S_DUMP;
          end
        end
      end
      S_POP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (res_ready_i && dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Queue bookkeeping: front index, count and the dump walk.
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    idx_d   = idx_q;
    if (state_q == S_IDLE && accept) begin
      unique case (op_i)
        OP_PUSH_BACK: begin
          if (!full) count_d = count_q + CW'(1);
        end
        OP_PUSH_FRONT: begin
          if (!full) begin
            front_d = front_dec;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) count_d = count_q - CW'(1);
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            front_d = front_inc;
            count_d = count_q - CW'(1);
          end
        end
        OP_DUMP: begin
          ptr_d = front_q;
          idx_d = '0;
        end
        default: ;
      endcase
    end else if (state_q == S_DUMP && res_ready_i) begin
      ptr_d = ptr_inc;
      idx_d = idx_q + CW'(1);
    end
  end

  // Outputs: store accesses and the result word.
  always_comb begin
    res_o            = '0;
    res_o.status     = ST_OK;
    res_o.occupancy  = occ_of(count_q);
    we_o             = 1'b0;
    waddr_o          = tail_pos;
    wdata_o          = value_i;
    re_o             = 1'b0;
    raddr_o          = front_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              res_o.valid = 1'b1;
              res_o.last  = 1'b1;
              if (full) begin
                res_o.status = ST_FULL;
              end else begin
                we_o            = 1'b1;
                waddr_o         = (op_i == OP_PUSH_BACK) ? tail_pos : front_dec;
                res_o.occupancy = occ_of(count_q + CW'(1));
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (empty) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                re_o    = 1'b1;
                raddr_o = (op_i == OP_POP_BACK) ? back_pos : front_q;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                re_o    = 1'b1;
                raddr_o = front_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        // Count was already lowered when the pop was taken.
        if (res_ready_i) begin
          res_o.valid      = 1'b1;
          res_o.last       = 1'b1;
          res_o.item_value = rdata_i;
        end
      end
      S_DUMP: begin
        // Emit the entry just read and fetch the next one unless it is the last.
        if (res_ready_i) begin
          res_o.valid      = 1'b1;
          res_o.last       = dump_last;
          res_o.item_value = rdata_i;
          if (!dump_last) begin
            re_o    = 1'b1;
            raddr_o = ptr_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
    end
  end

endmodule
